// ===== rtl/typed_socket_timer_queue_defines.svh =====
// Assertion macros for the timer queue, clocked on aclk and disabled in reset.
`ifndef TYPED_SOCKET_TIMER_QUEUE_DEFINES_SVH
`define TYPED_SOCKET_TIMER_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSTQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tstq_pkg.sv =====
package tstq_pkg;

    localparam int TIMER_SLOTS = 32;
    localparam int MAX_OUT     = 32;
    localparam int SCAN_LIMIT  = (TIMER_SLOTS < MAX_OUT) ? TIMER_SLOTS : MAX_OUT;
    localparam int IDX_W       = $clog2(TIMER_SLOTS);
    localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
    localparam int MEM_DEPTH   = 1 << IDX_W;

    typedef logic [47:0] time_t;

    localparam logic [31:0] OTHER_TIMEOUT_MS = 32'd10000;
    localparam logic [31:0] BIND_RESET_MS    = 32'd30000;
    localparam logic [31:0] ACT_RESET_MS     = 32'd60000;
    localparam logic [31:0] CONN_RESET_MS    = 32'd10000;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    localparam logic [1:0] TMR_BIND     = 2'd0;
    localparam logic [1:0] TMR_ACTIVITY = 2'd1;
    localparam logic [1:0] TMR_CONNECT  = 2'd2;

    localparam logic [1:0] REG_BIND     = 2'd0;
    localparam logic [1:0] REG_ACTIVITY = 2'd1;
    localparam logic [1:0] REG_CONNECT  = 2'd2;

    localparam logic [2:0] KIND_ADDED   = 3'd0;
    localparam logic [2:0] KIND_DROPPED = 3'd1;
    localparam logic [2:0] KIND_REMOVED = 3'd2;
    localparam logic [2:0] KIND_EXPIRED = 3'd3;
    localparam logic [2:0] KIND_NONE    = 3'd4;

    typedef struct packed {
        time_t       alarm;
        logic [15:0] socket;
        logic [1:0]  kind;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_WALK,
        ST_ADD_PUT,
        ST_REM_WALK,
        ST_TICK_SCAN,
        ST_TICK_EMIT,
        ST_TICK_SHIFT,
        ST_RESP
    } state_t;

endpackage

// ===== rtl/typed_socket_timer_queue.sv =====
// Timer queue kept sorted by alarm time, with equal alarms in the order they were added.
// The input channel (s_valid/s_ready) takes one request transaction at a time: an add,
// a remove of all timers of one socket, or a tick. The result channel (m_valid/m_ready)
// gives one transaction per add or remove, and one per expired timer or a single
// "none expired" transaction per tick, with m_last on the final one of each request.
// The three timeouts are written through cfg_we/cfg_index/cfg_wdata; the user must
// do so only while idle, as the block itself does not enforce it. All timers sit in
// one single-port-read table walked one entry per cycle, except while a full output
// register holds it, by a small sequencer with separate compares for alarm order,
// socket match and expiry; s_ready is low while a request is worked on.
// An expired timer is read from the table in the cycle before it is sent, so results
// of a tick appear one per cycle while the receiver keeps m_ready high.
// A full output register stalls the sequencer until m_ready takes the transaction;
// no result is dropped. After a synchronous reset (aresetn low) the table is empty,
// the timeouts hold their default values and no result is pending.
`include "typed_socket_timer_queue_defines.svh"

module typed_socket_timer_queue
    import tstq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [15:0] s_socket_id,
    input  logic [1:0]  s_timer_type,
    input  logic [47:0] s_now_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_result_kind,
    output logic [15:0] m_out_socket,
    output logic [1:0]  m_out_type,
    output logic [47:0] m_fire_time_ms,
    output logic [6:0]  m_removed_count,
    output logic        m_last
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   live_count_reg, live_count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   wr_reg, wr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    entry_t             new_reg, new_next;
    time_t              now_reg, now_next;
    logic [2:0]         resp_kind_reg, resp_kind_next;
    logic [31:0]        bind_reg, act_reg, conn_reg;

    entry_t             mem [MEM_DEPTH];
    entry_t             rdata_reg;
    logic               mem_we;
    logic [CNT_W-1:0]   mem_waddr;
    entry_t             mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;

    logic               m_valid_reg;
    logic [2:0]         out_kind_reg;
    logic [15:0]        out_socket_reg;
    logic [1:0]         out_type_reg;
    time_t              out_fire_reg;
    logic [6:0]         out_count_reg;
    logic               out_last_reg;
    logic               out_load;

    logic               in_fire;
    logic               out_free;
    logic               table_full;
    logic               table_empty;
    logic [CNT_W-1:0]   live_last;
    logic [CNT_W-1:0]   ptr_inc;
    logic               ptr_zero;
    logic               rd_gt;
    logic               rd_match;
    logic               rd_hit;
    logic               ptr_at_end;
    logic               scan_stop;
    logic               emit_last;
    logic [31:0]        delta;
    logic [48:0]        alarm_sum;
    time_t              alarm_calc;

    assign s_ready     = (state_reg == ST_IDLE);
    assign in_fire     = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign table_full  = (live_count_reg == CNT_W'(TIMER_SLOTS));
    assign table_empty = (live_count_reg == '0);
    assign live_last   = live_count_reg - 1'b1;
    assign ptr_inc     = ptr_reg + 1'b1;
    assign ptr_zero    = (ptr_reg == '0);
    assign rd_gt       = (rdata_reg.alarm > new_reg.alarm);
    assign rd_match    = (rdata_reg.socket == new_reg.socket);
    assign rd_hit      = (rdata_reg.alarm <= now_reg);
    assign ptr_at_end  = (ptr_inc == live_count_reg);
    assign scan_stop   = ptr_at_end || (ptr_inc == CNT_W'(SCAN_LIMIT));
    assign emit_last   = (ptr_inc == cnt_reg);

    always_comb begin
        case (s_timer_type)
            TMR_BIND:     delta = bind_reg;
            TMR_ACTIVITY: delta = act_reg;
            TMR_CONNECT:  delta = conn_reg;
            default:      delta = OTHER_TIMEOUT_MS;
        endcase
    end

    assign alarm_sum  = {1'b0, s_now_ms} + {17'd0, delta};
    assign alarm_calc = alarm_sum[48] ? '1 : alarm_sum[47:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (s_req_type)
                        REQ_ADD:    state_next = (table_full || table_empty) ? ST_RESP
                                                                             : ST_ADD_WALK;
                        REQ_REMOVE: state_next = table_empty ? ST_RESP : ST_REM_WALK;
                        REQ_TICK:   state_next = table_empty ? ST_RESP : ST_TICK_SCAN;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_WALK: begin
                if (!rd_gt) begin
                    state_next = ST_RESP;
                end else if (ptr_zero) begin
                    state_next = ST_ADD_PUT;
                end
            end
            ST_ADD_PUT: state_next = ST_RESP;
            ST_REM_WALK: begin
                if (ptr_at_end) begin
                    state_next = ST_RESP;
                end
            end
            ST_TICK_SCAN: begin
                if (rd_hit) begin
                    if (scan_stop) begin
                        state_next = ST_TICK_EMIT;
                    end
                end else begin
                    state_next = ptr_zero ? ST_RESP : ST_TICK_EMIT;
                end
            end
            ST_TICK_EMIT: begin
                if (out_free && emit_last) begin
                    state_next = (cnt_reg == live_count_reg) ? ST_IDLE : ST_TICK_SHIFT;
                end
            end
            ST_TICK_SHIFT: begin
                if (ptr_at_end) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        live_count_next = live_count_reg;
        ptr_next        = ptr_reg;
        wr_next         = wr_reg;
        cnt_next        = cnt_reg;
        new_next        = new_reg;
        now_next        = now_reg;
        resp_kind_next  = resp_kind_reg;
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg;
        mem_wdata       = rdata_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    new_next = '{alarm: alarm_calc, socket: s_socket_id, kind: s_timer_type};
                    now_next = s_now_ms;
                    cnt_next = '0;
                    wr_next  = '0;
                    ptr_next = '0;
                    case (s_req_type)
                        REQ_ADD: begin
                            resp_kind_next = table_full ? KIND_DROPPED : KIND_ADDED;
                            if (!table_full) begin
                                if (table_empty) begin
                                    mem_we          = 1'b1;
                                    mem_waddr       = '0;
                                    mem_wdata       = '{alarm: alarm_calc, socket: s_socket_id,
                                                        kind: s_timer_type};
                                    live_count_next = live_count_reg + 1'b1;
                                end else begin
                                    ptr_next = live_last;
                                end
                            end
                        end
                        REQ_REMOVE: resp_kind_next = KIND_REMOVED;
                        REQ_TICK:   resp_kind_next = KIND_NONE;
                        default:    resp_kind_next = resp_kind_reg;
                    endcase
                end
            end
            ST_ADD_WALK: begin
                mem_we = 1'b1;
                mem_waddr = ptr_inc;
                if (rd_gt) begin
                    mem_wdata = rdata_reg;
                    if (!ptr_zero) begin
                        ptr_next = ptr_reg - 1'b1;
                    end
                end else begin
                    mem_wdata       = new_reg;
                    live_count_next = live_count_reg + 1'b1;
                end
            end
            ST_ADD_PUT: begin
                mem_we          = 1'b1;
                mem_waddr       = '0;
                mem_wdata       = new_reg;
                live_count_next = live_count_reg + 1'b1;
            end
            ST_REM_WALK: begin
                if (rd_match) begin
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_reg;
                    wr_next   = wr_reg + 1'b1;
                end
                if (ptr_at_end) begin
                    live_count_next = rd_match ? wr_reg : wr_reg + 1'b1;
                end else begin
                    ptr_next = ptr_inc;
                end
            end
            ST_TICK_SCAN: begin
                if (rd_hit) begin
                    if (scan_stop) begin
                        cnt_next = ptr_inc;
                        ptr_next = '0;
                    end else begin
                        ptr_next = ptr_inc;
                    end
                end else begin
                    cnt_next = ptr_reg;
                    ptr_next = '0;
                end
            end
            ST_TICK_EMIT: begin
                if (out_free) begin
                    if (emit_last) begin
                        if (cnt_reg == live_count_reg) begin
                            live_count_next = '0;
                        end else begin
                            ptr_next = cnt_reg;
                        end
                    end else begin
                        ptr_next = ptr_inc;
                    end
                end
            end
            ST_TICK_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg - cnt_reg;
                if (ptr_at_end) begin
                    live_count_next = live_count_reg - cnt_reg;
                end else begin
                    ptr_next = ptr_inc;
                end
            end
            default: begin
            end
        endcase
    end

    assign mem_raddr = ptr_next[IDX_W-1:0];
    assign out_load  = out_free && ((state_reg == ST_TICK_EMIT) || (state_reg == ST_RESP));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr[IDX_W-1:0]] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            live_count_reg <= '0;
            ptr_reg        <= '0;
            wr_reg         <= '0;
            cnt_reg        <= '0;
            resp_kind_reg  <= KIND_ADDED;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            live_count_reg <= live_count_next;
            ptr_reg        <= ptr_next;
            wr_reg         <= wr_next;
            cnt_reg        <= cnt_next;
            resp_kind_reg  <= resp_kind_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        new_reg <= new_next;
        now_reg <= now_next;
        if (out_load) begin
            if (state_reg == ST_TICK_EMIT) begin
                out_kind_reg   <= KIND_EXPIRED;
                out_socket_reg <= rdata_reg.socket;
                out_type_reg   <= rdata_reg.kind;
                out_fire_reg   <= now_reg;
                out_count_reg  <= '0;
                out_last_reg   <= emit_last;
            end else begin
                out_kind_reg   <= resp_kind_reg;
                out_socket_reg <= '0;
                out_type_reg   <= '0;
                out_fire_reg   <= (resp_kind_reg == KIND_NONE) ? now_reg : '0;
                out_count_reg  <= (resp_kind_reg == KIND_REMOVED) ? 7'(cnt_reg) : '0;
                out_last_reg   <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bind_reg <= BIND_RESET_MS;
            act_reg  <= ACT_RESET_MS;
            conn_reg <= CONN_RESET_MS;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BIND:     bind_reg <= cfg_wdata;
                REG_ACTIVITY: act_reg  <= cfg_wdata;
                REG_CONNECT:  conn_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_kind   = out_kind_reg;
    assign m_out_socket    = out_socket_reg;
    assign m_out_type      = out_type_reg;
    assign m_fire_time_ms  = out_fire_reg;
    assign m_removed_count = out_count_reg;
    assign m_last          = out_last_reg;

    `TSTQ_ASSERT_SAME(a_live_bound, 1'b1, live_count_reg <= CNT_W'(TIMER_SLOTS),
        "live timer count exceeds the table size")
    `TSTQ_ASSERT_NEXT(a_full_drop,
        in_fire && (s_req_type == REQ_ADD) && table_full,
        (state_reg == ST_RESP) && (resp_kind_reg == KIND_DROPPED) && table_full,
        "add to a full table was not dropped")
    `TSTQ_ASSERT_SAME(a_emit_range, state_reg == ST_TICK_EMIT,
        (ptr_reg < cnt_reg) && (cnt_reg <= live_count_reg),
        "expiry index outside the expired range")
    `TSTQ_ASSERT_SAME(a_emit_due, (state_reg == ST_TICK_EMIT) && out_free,
        rdata_reg.alarm <= now_reg,
        "timer sent as expired before its alarm")

endmodule

// ===== test/tb_typed_socket_timer_queue.sv =====
`timescale 1ns / 1ps

module tb_typed_socket_timer_queue;
    import tstq_pkg::*;

    localparam logic [1:0] REQ_UNUSED     = 2'd3;
    localparam logic [1:0] TMR_OTHER      = 2'd3;
    localparam logic [1:0] REG_UNUSED     = 2'd3;
    localparam time_t      TIME_MAX       = '1;
    localparam int         RX_HOLD_CYCLES = 300;
    localparam int         SETTLE_CYCLES  = 80;
    localparam int         WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] socket;
        logic [1:0]  ttype;
        time_t       fire;
        logic [6:0]  count;
        logic        last;
    } timer_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [15:0] s_socket_id;
    logic [1:0]  s_timer_type;
    logic [47:0] s_now_ms;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_result_kind;
    logic [15:0] m_out_socket;
    logic [1:0]  m_out_type;
    logic [47:0] m_fire_time_ms;
    logic [6:0]  m_removed_count;
    logic        m_last;

    typed_socket_timer_queue u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_socket_id     (s_socket_id),
        .s_timer_type    (s_timer_type),
        .s_now_ms        (s_now_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_out_socket    (m_out_socket),
        .m_out_type      (m_out_type),
        .m_fire_time_ms  (m_fire_time_ms),
        .m_removed_count (m_removed_count),
        .m_last          (m_last)
    );

    always #5 aclk = ~aclk;

    class timer_scoreboard;
        logic [31:0]   bind_ms;
        logic [31:0]   activity_ms;
        logic [31:0]   connect_ms;
        entry_t        timers[$];
        timer_result_t expected[$];
        int            errors;

        function new();
            bind_ms     = BIND_RESET_MS;
            activity_ms = ACT_RESET_MS;
            connect_ms  = CONN_RESET_MS;
            errors      = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [31:0] value);
            case (index)
                REG_BIND:     bind_ms = value;
                REG_ACTIVITY: activity_ms = value;
                REG_CONNECT:  connect_ms = value;
                default:      ;
            endcase
        endfunction

        function void note_request(logic [1:0] req, logic [15:0] sock, logic [1:0] ttype,
                                   time_t now);
            timer_result_t res;
            entry_t        e;
            entry_t        kept[$];
            logic [31:0]   delta;
            logic [48:0]   sum;
            int            pos;
            int            hits;
            int            n;
            res = '0;
            res.last = 1'b1;
            case (req)
                REQ_ADD: begin
                    if (timers.size() >= TIMER_SLOTS) begin
                        res.kind = KIND_DROPPED;
                    end else begin
                        case (ttype)
                            TMR_BIND:     delta = bind_ms;
                            TMR_ACTIVITY: delta = activity_ms;
                            TMR_CONNECT:  delta = connect_ms;
                            default:      delta = OTHER_TIMEOUT_MS;
                        endcase
                        sum = {1'b0, now} + {17'd0, delta};
                        e.alarm  = sum[48] ? TIME_MAX : sum[47:0];
                        e.socket = sock;
                        e.kind   = ttype;
                        pos = timers.size();
                        while (pos > 0 && timers[pos - 1].alarm > e.alarm) pos--;
                        timers.insert(pos, e);
                        res.kind = KIND_ADDED;
                    end
                    expected.insert(expected.size(), res);
                end
                REQ_REMOVE: begin
                    hits = 0;
                    foreach (timers[i]) begin
                        if (timers[i].socket == sock) hits++;
                        else kept.insert(kept.size(), timers[i]);
                    end
                    timers = kept;
                    res.kind  = KIND_REMOVED;
                    res.count = 7'(hits);
                    expected.insert(expected.size(), res);
                end
                REQ_TICK: begin
                    n = 0;
                    while (n < timers.size() && n < MAX_OUT && timers[n].alarm <= now) n++;
                    res.fire = now;
                    if (n == 0) begin
                        res.kind = KIND_NONE;
                        expected.insert(expected.size(), res);
                    end else begin
                        for (int i = 0; i < n; i++) begin
                            res.kind   = KIND_EXPIRED;
                            res.socket = timers[0].socket;
                            res.ttype  = timers[0].kind;
                            res.last   = (i == n - 1);
                            expected.insert(expected.size(), res);
                            void'(timers.pop_front());
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [47:0] want, logic [47:0] got);
            if (want !== got) begin
                errors++;
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            end
        endfunction

        function void check_result(timer_result_t got);
            timer_result_t want;
            if (expected.size() == 0) begin
                errors++;
                $error("result transaction with nothing expected: result_kind %0d", got.kind);
                return;
            end
            want = expected.pop_front();
            compare_field("result_kind", 48'(want.kind), 48'(got.kind));
            compare_field("out_socket", 48'(want.socket), 48'(got.socket));
            compare_field("out_type", 48'(want.ttype), 48'(got.ttype));
            compare_field("fire_time_ms", want.fire, got.fire);
            compare_field("removed_count", 48'(want.count), 48'(got.count));
            compare_field("last", 48'(want.last), 48'(got.last));
        endfunction
    endclass

    timer_scoreboard sb;
    int              in_accepts = 0;
    int              items_sent = 0;
    int              stall_cycles = 0;
    int              tx_idle_pct;
    int              rx_idle_pct;
    bit              hold_req = 1'b0;
    logic [15:0]     socket_pool[8];
    timer_result_t   seen_result;
    logic            any_transaction;

    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            any_transaction = 1'b0;
            if (s_valid && s_ready) begin
                sb.note_request(s_req_type, s_socket_id, s_timer_type, s_now_ms);
                in_accepts++;
                any_transaction = 1'b1;
            end
            if (m_valid && m_ready) begin
                seen_result.kind   = m_result_kind;
                seen_result.socket = m_out_socket;
                seen_result.ttype  = m_out_type;
                seen_result.fire   = m_fire_time_ms;
                seen_result.count  = m_removed_count;
                seen_result.last   = m_last;
                sb.check_result(seen_result);
                any_transaction = 1'b1;
            end
            if (any_transaction) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("typed_socket_timer_queue regression: fail");
                $finish;
            end
        end
    end

    // The receiver stalls at random; on request it holds off for a long stretch.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    function automatic time_t random_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    function automatic logic [15:0] pick_socket();
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return socket_pool[$urandom_range(0, 7)];
    endfunction

    task automatic send_request(input logic [1:0] req, input logic [15:0] sock,
                                input logic [1:0] ttype, input time_t now);
        int seen;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_socket_id  <= sock;
        s_timer_type <= ttype;
        s_now_ms     <= now;
        seen = in_accepts;
        do @(negedge aclk); while (in_accepts == seen);
        if (req != REQ_UNUSED) items_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.expected.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        sb.write_reg(index, value);
    endtask

    // Fills the table past its capacity, then expires everything with the largest time.
    task automatic fill_table();
        int extra;
        extra = TIMER_SLOTS - sb.timers.size() + $urandom_range(1, 2);
        repeat (extra) send_request(REQ_ADD, pick_socket(), 2'($urandom), random_time());
        send_request(REQ_TICK, pick_socket(), 2'($urandom), TIME_MAX);
    endtask

    task automatic run_directed();
        send_request(REQ_TICK, 16'h0000, TMR_BIND, 48'd0);
        send_request(REQ_REMOVE, 16'h0000, TMR_BIND, 48'd0);
        send_request(REQ_ADD, 16'h0000, TMR_BIND, 48'd0);
        send_request(REQ_ADD, 16'hFFFF, TMR_ACTIVITY, 48'd0);
        send_request(REQ_ADD, 16'h1234, TMR_CONNECT, 48'd20000);
        send_request(REQ_ADD, 16'h5555, TMR_OTHER, 48'd20000);
        send_request(REQ_ADD, 16'hAAAA, TMR_OTHER, TIME_MAX);
        send_request(REQ_ADD, 16'h8001, TMR_BIND, 48'hFFFF_FFFF_F000);
        send_request(REQ_UNUSED, 16'($urandom), 2'($urandom), random_time());
        send_request(REQ_TICK, 16'hFFFF, TMR_OTHER, 48'd29999);
        send_request(REQ_TICK, 16'h0000, TMR_BIND, 48'd30000);
        send_request(REQ_REMOVE, 16'hFFFF, TMR_OTHER, TIME_MAX);
        send_request(REQ_ADD, 16'h0007, TMR_CONNECT, 48'd1000);
        send_request(REQ_ADD, 16'h0007, TMR_BIND, 48'd1000);
        send_request(REQ_ADD, 16'h0008, TMR_OTHER, 48'd1000);
        send_request(REQ_ADD, 16'h0007, TMR_ACTIVITY, 48'd1000);
        send_request(REQ_REMOVE, 16'h0007, TMR_BIND, 48'd0);
        send_request(REQ_TICK, 16'h0000, TMR_BIND, TIME_MAX - 48'd1);
        send_request(REQ_TICK, 16'h0000, TMR_BIND, TIME_MAX);
        send_request(REQ_REMOVE, 16'h0000, TMR_BIND, 48'd0);
    endtask

    task automatic run_phase(input int target, input bit with_fill);
        int    goal;
        int    shape;
        time_t cur_ms;
        goal = items_sent + target;
        cur_ms = time_t'($urandom_range(0, 1000000));
        if (with_fill) fill_table();
        while (items_sent < goal) begin
            shape = $urandom_range(0, 99);
            if (shape < 72) begin
                repeat ($urandom_range(1, 6)) begin
                    send_request(REQ_ADD, pick_socket(), 2'($urandom), cur_ms);
                    cur_ms += $urandom_range(0, 3000);
                end
                if ($urandom_range(0, 99) < 35)
                    send_request(REQ_REMOVE, pick_socket(), 2'($urandom), random_time());
                cur_ms += $urandom_range(0, 40000);
                send_request(REQ_TICK, pick_socket(), 2'($urandom), cur_ms);
            end else if (shape < 78) begin
                fill_table();
            end else begin
                send_request(2'($urandom), 16'($urandom), 2'($urandom), random_time());
            end
        end
    endtask

    initial begin
        sb = new();
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_BIND;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_req_type   = REQ_ADD;
        s_socket_id  = '0;
        s_timer_type = TMR_BIND;
        s_now_ms     = '0;
        tx_idle_pct  = 33;
        rx_idle_pct  = 59;
        socket_pool[0] = 16'h0000;
        socket_pool[1] = 16'hFFFF;
        for (int i = 2; i < 8; i++) socket_pool[i] = 16'($urandom);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        run_directed();
        drain_results();

        write_reg(REG_BIND, 32'd0);
        write_reg(REG_ACTIVITY, 32'hFFFF_FFFF);
        write_reg(REG_CONNECT, 32'd1);
        write_reg(REG_UNUSED, $urandom);
        run_phase(40, 1'b1);
        drain_results();

        tx_idle_pct = 59;
        rx_idle_pct = 33;
        write_reg(REG_BIND, 32'hFFFF_FFFF);
        write_reg(REG_ACTIVITY, 32'd0);
        write_reg(REG_CONNECT, $urandom_range(0, 20000));
        // The receiver stops taking results while the sender keeps offering requests.
        hold_req = 1'b1;
        run_phase(40, 1'b0);
        drain_results();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(REG_BIND, $urandom_range(0, 80000));
        write_reg(REG_ACTIVITY, $urandom_range(0, 80000));
        write_reg(REG_CONNECT, $urandom_range(0, 80000));
        run_phase(40, 1'b1);
        drain_results();

        if (sb.errors == 0) begin
            $display("typed_socket_timer_queue regression: pass");
        end else begin
            $display("typed_socket_timer_queue regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tstq_pkg.sv
rtl/typed_socket_timer_queue.sv
test/tb_typed_socket_timer_queue.sv
